### rtl/dltq_pkg.sv
// Package for the delta-list timer queue: codes, list entry type and the
// command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  localparam int ID_W     = 4;
  localparam int DELTA_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  // Timer ids are 4 bits wide, so no more than this many can ever be queued.
  localparam int ID_COUNT = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_EXPIRED = 3'd1,
    ST_NONE    = 3'd2,
    ST_NOTQ    = 3'd3,
    ST_REJECT  = 3'd4
  } status_e;

  // One slot of the list: timer id and ticks after the previous slot.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELTA_W-1:0] delta;
  } entry_t;

  typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} idx_op_e;
  typedef enum logic [1:0] {WR_NEW, WR_CARRY, WR_HEAD, WR_MOVED} wr_src_e;
  typedef enum logic [1:0] {REM_HOLD, REM_SUB, REM_RD, REM_CLR} rem_op_e;
  typedef enum logic [1:0] {CARRY_HOLD, CARRY_SPLIT, CARRY_RD} carry_op_e;
  typedef enum logic [1:0] {SH_HOLD, SH_ONE, SH_IDX} shift_op_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_SUB_SHIFT, CNT_SUB_IDX} cnt_op_e;
  typedef enum logic [1:0] {MASK_HOLD, MASK_SET_ID, MASK_CLR_ID, MASK_CLR_RD} mask_op_e;
  typedef enum logic [1:0] {EID_CMD, EID_PEND, EID_ZERO} emit_id_e;

  // Controller to datapath
  typedef struct packed {
    logic      load;
    idx_op_e   idx_op;
    logic      wr_en;
    wr_src_e   wr_src;
    logic      wr_back;     // write at idx - shift instead of idx
    rem_op_e   rem_op;
    carry_op_e carry_op;
    shift_op_e shift_op;
    logic      pend_load;
    cnt_op_e   cnt_op;
    mask_op_e  mask_op;
    logic      emit;
    status_e   emit_status;
    emit_id_e  emit_id;
    logic      emit_last;
  } dp_ctl_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic add_ok;
    logic queued;
    logic empty;
    logic at_end;
    logic rem_lt;
    logic id_match;
    logic rd_delta_zero;
    logic head_expire;
  } dp_stat_t;

endpackage

`default_nettype wire

### rtl/dltq_dp.sv
// Datapath of the delta-list timer queue: list memory, walk index, running
// remainder, carry slot, count, queued mask and result registers.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dltq_dp #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dltq_pkg::dp_ctl_t             ctl_i,
  output dltq_pkg::dp_stat_t            stat_o,
  input  logic [dltq_pkg::CMD_W-1:0]    cmd_i,
  input  logic [dltq_pkg::ID_W-1:0]     timer_id_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  delay_ticks_i,
  output logic                          result_valid_o,
  output logic [dltq_pkg::STATUS_W-1:0] status_o,
  output logic [dltq_pkg::ID_W-1:0]     fired_id_o,
  output logic                          last_o
);

  localparam int DEPTH = (NUM_TIMERS < dltq_pkg::ID_COUNT) ? NUM_TIMERS : dltq_pkg::ID_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  dltq_pkg::entry_t mem_q [DEPTH];
  dltq_pkg::entry_t rd_q;
  dltq_pkg::entry_t carry_q, carry_d;
  dltq_pkg::entry_t wr_data;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] shift_q, shift_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DEPTH-1:0] mask_q, mask_d;

  dltq_pkg::cmd_e                 cmd_q;
  logic [dltq_pkg::ID_W-1:0]      id_q;
  logic [dltq_pkg::ID_W-1:0]      pend_q;
  logic [dltq_pkg::DELTA_W-1:0]   rem_q, rem_d;
  logic [dltq_pkg::DELTA_W-1:0]   head_dec;
  logic                           id_ok;
  logic                           queued;

  logic                           res_valid_q;
  dltq_pkg::status_e              res_status_q;
  logic [dltq_pkg::ID_W-1:0]      res_id_q;
  logic                           res_last_q;

  // Status toward the controller
  assign id_ok    = int'(id_q) < DEPTH;
  assign queued   = id_ok && mask_q[id_q[AW-1:0]];
  assign head_dec = (rd_q.delta == '0) ? '0 : rd_q.delta - 1'b1;

  always_comb begin
    stat_o.cmd           = cmd_q;
    stat_o.queued        = queued;
    stat_o.add_ok        = (rem_q != '0) && id_ok && !queued && (int'(cnt_q) < DEPTH);
    stat_o.empty         = (cnt_q == '0);
    stat_o.at_end        = (idx_q == cnt_q);
    stat_o.rem_lt        = (rem_q < rd_q.delta);
    stat_o.id_match      = (rd_q.id == id_q);
    stat_o.rd_delta_zero = (rd_q.delta == '0);
    stat_o.head_expire   = (rd_q.delta[dltq_pkg::DELTA_W-1:1] == '0);
  end

  // Walk index; the memory is read at the next index so data lines up
  always_comb begin
    case (ctl_i.idx_op)
      dltq_pkg::IDX_CLR: idx_d = '0;
      dltq_pkg::IDX_INC: idx_d = idx_q + CW'(1);
      default:           idx_d = idx_q;
    endcase
  end
  assign rd_addr = idx_d[AW-1:0];

  // Write port data and address
  always_comb begin
    case (ctl_i.wr_src)
      dltq_pkg::WR_NEW: begin
        wr_data.id    = id_q;
        wr_data.delta = rem_q;
      end
      dltq_pkg::WR_CARRY: wr_data = carry_q;
      dltq_pkg::WR_HEAD: begin
        wr_data.id    = rd_q.id;
        wr_data.delta = head_dec;
      end
      default: begin
        wr_data.id    = rd_q.id;
        wr_data.delta = rd_q.delta + rem_q;
      end
    endcase
  end
  assign wr_addr = ctl_i.wr_back ? AW'(idx_q - shift_q) : idx_q[AW-1:0];

  // List memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Remainder, carry and shift
  always_comb begin
    case (ctl_i.rem_op)
      dltq_pkg::REM_SUB: rem_d = rem_q - rd_q.delta;
      dltq_pkg::REM_RD:  rem_d = rd_q.delta;
      dltq_pkg::REM_CLR: rem_d = '0;
      default:           rem_d = rem_q;
    endcase
    if (ctl_i.load) begin
      rem_d = delay_ticks_i;
    end

    case (ctl_i.carry_op)
      dltq_pkg::CARRY_SPLIT: begin
        carry_d.id    = rd_q.id;
        carry_d.delta = rd_q.delta - rem_q;
      end
      dltq_pkg::CARRY_RD: carry_d = rd_q;
      default:            carry_d = carry_q;
    endcase

    case (ctl_i.shift_op)
      dltq_pkg::SH_ONE: shift_d = CW'(1);
      dltq_pkg::SH_IDX: shift_d = idx_q;
      default:          shift_d = shift_q;
    endcase
  end

  // Entry count and queued mask
  always_comb begin
    case (ctl_i.cnt_op)
      dltq_pkg::CNT_INC:       cnt_d = cnt_q + CW'(1);
      dltq_pkg::CNT_SUB_SHIFT: cnt_d = cnt_q - shift_q;
      dltq_pkg::CNT_SUB_IDX:   cnt_d = cnt_q - idx_q;
      default:                 cnt_d = cnt_q;
    endcase

    mask_d = mask_q;
    case (ctl_i.mask_op)
      dltq_pkg::MASK_SET_ID: mask_d[id_q[AW-1:0]]    = 1'b1;
      dltq_pkg::MASK_CLR_ID: mask_d[id_q[AW-1:0]]    = 1'b0;
      dltq_pkg::MASK_CLR_RD: mask_d[rd_q.id[AW-1:0]] = 1'b0;
      default:               mask_d = mask_q;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      mask_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      mask_q      <= mask_d;
      res_valid_q <= ctl_i.emit;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    carry_q <= carry_d;
    shift_q <= shift_d;
    if (ctl_i.load) begin
      cmd_q <= dltq_pkg::cmd_e'(cmd_i);
      id_q  <= timer_id_i;
    end
    if (ctl_i.pend_load) begin
      pend_q <= rd_q.id;
    end
    if (ctl_i.emit) begin
      res_status_q <= ctl_i.emit_status;
      res_last_q   <= ctl_i.emit_last;
      case (ctl_i.emit_id)
        dltq_pkg::EID_CMD:  res_id_q <= id_q;
        dltq_pkg::EID_PEND: res_id_q <= pend_q;
        default:            res_id_q <= '0;
      endcase
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign fired_id_o     = res_id_q;
  assign last_o         = res_last_q;

`ifndef SYNTH
  // Between commands the mask and the count agree
  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.load |-> $countones(mask_q) == int'(cnt_q))
    else $error("queued mask and entry count disagree");

  // Writes never land beyond the end of the list
  a_wr_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.wr_en |-> CW'(wr_addr) <= cnt_q)
    else $error("list write beyond entry count");
`endif

endmodule

`default_nettype wire

### rtl/dltq_ctrl.sv
// Controller of the delta-list timer queue: sequences add, delete and tick
// walks over the list memory through command and status structs.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dltq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  dltq_pkg::dp_stat_t stat_i,
  output dltq_pkg::dp_ctl_t  ctl_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_ADD_SEEK = 7'b0000100,
    S_ADD_SHFT = 7'b0001000,
    S_DEL_SEEK = 7'b0010000,
    S_POP      = 7'b0100000,
    S_MOVE     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load   = 1'b1;
          ctl_o.idx_op = dltq_pkg::IDX_CLR;
          state_d      = S_DISPATCH;
        end
      end

      // Checks, and the head of a tick; mem[0] is on the read port
      S_DISPATCH: begin
        ctl_o.emit_id   = dltq_pkg::EID_CMD;
        ctl_o.emit_last = 1'b1;
        case (stat_i.cmd)
          dltq_pkg::CMD_ADD: begin
            if (stat_i.add_ok) begin
              state_d = S_ADD_SEEK;
            end else begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = dltq_pkg::ST_REJECT;
              state_d           = S_IDLE;
            end
          end
          dltq_pkg::CMD_DEL: begin
            if (stat_i.queued) begin
              state_d = S_DEL_SEEK;
            end else begin
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = dltq_pkg::ST_NOTQ;
              state_d           = S_IDLE;
            end
          end
          dltq_pkg::CMD_TICK: begin
            if (stat_i.empty || !stat_i.head_expire) begin
              ctl_o.wr_en       = !stat_i.empty;
              ctl_o.wr_src      = dltq_pkg::WR_HEAD;
              ctl_o.emit        = 1'b1;
              ctl_o.emit_status = dltq_pkg::ST_NONE;
              ctl_o.emit_id     = dltq_pkg::EID_ZERO;
              state_d           = S_IDLE;
            end else begin
              ctl_o.pend_load = 1'b1;
              ctl_o.mask_op   = dltq_pkg::MASK_CLR_RD;
              ctl_o.idx_op    = dltq_pkg::IDX_INC;
              state_d         = S_POP;
            end
          end
          default: begin
            ctl_o.emit        = 1'b1;
            ctl_o.emit_status = dltq_pkg::ST_REJECT;
            state_d           = S_IDLE;
          end
        endcase
      end

      // Subtract deltas until the new timer falls before an entry
      S_ADD_SEEK: begin
        if (stat_i.at_end) begin
          ctl_o.wr_en       = 1'b1;
          ctl_o.wr_src      = dltq_pkg::WR_NEW;
          ctl_o.cnt_op      = dltq_pkg::CNT_INC;
          ctl_o.mask_op     = dltq_pkg::MASK_SET_ID;
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = dltq_pkg::ST_DONE;
          ctl_o.emit_id     = dltq_pkg::EID_CMD;
          ctl_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else if (stat_i.rem_lt) begin
          ctl_o.wr_en    = 1'b1;
          ctl_o.wr_src   = dltq_pkg::WR_NEW;
          ctl_o.carry_op = dltq_pkg::CARRY_SPLIT;
          ctl_o.idx_op   = dltq_pkg::IDX_INC;
          state_d        = S_ADD_SHFT;
        end else begin
          ctl_o.rem_op = dltq_pkg::REM_SUB;
          ctl_o.idx_op = dltq_pkg::IDX_INC;
        end
      end

      // Ripple the displaced entry one slot up
      S_ADD_SHFT: begin
        ctl_o.wr_en  = 1'b1;
        ctl_o.wr_src = dltq_pkg::WR_CARRY;
        if (stat_i.at_end) begin
          ctl_o.cnt_op      = dltq_pkg::CNT_INC;
          ctl_o.mask_op     = dltq_pkg::MASK_SET_ID;
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = dltq_pkg::ST_DONE;
          ctl_o.emit_id     = dltq_pkg::EID_CMD;
          ctl_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          ctl_o.carry_op = dltq_pkg::CARRY_RD;
          ctl_o.idx_op   = dltq_pkg::IDX_INC;
        end
      end

      // Find the entry; its delta is folded into the successor
      S_DEL_SEEK: begin
        if (stat_i.id_match) begin
          ctl_o.rem_op   = dltq_pkg::REM_RD;
          ctl_o.shift_op = dltq_pkg::SH_ONE;
          ctl_o.idx_op   = dltq_pkg::IDX_INC;
          state_d        = S_MOVE;
        end else if (stat_i.at_end) begin
          ctl_o.emit        = 1'b1;
          ctl_o.emit_status = dltq_pkg::ST_NOTQ;
          ctl_o.emit_id     = dltq_pkg::EID_CMD;
          ctl_o.emit_last   = 1'b1;
          state_d           = S_IDLE;
        end else begin
          ctl_o.idx_op = dltq_pkg::IDX_INC;
        end
      end

      // Report each expired entry once the one after it is known
      S_POP: begin
        ctl_o.emit        = 1'b1;
        ctl_o.emit_status = dltq_pkg::ST_EXPIRED;
        ctl_o.emit_id     = dltq_pkg::EID_PEND;
        if (stat_i.at_end) begin
          ctl_o.emit_last = 1'b1;
          ctl_o.cnt_op    = dltq_pkg::CNT_SUB_IDX;
          state_d         = S_IDLE;
        end else if (!stat_i.rd_delta_zero) begin
          ctl_o.emit_last = 1'b1;
          ctl_o.shift_op  = dltq_pkg::SH_IDX;
          ctl_o.rem_op    = dltq_pkg::REM_CLR;
          state_d         = S_MOVE;
        end else begin
          ctl_o.pend_load = 1'b1;
          ctl_o.mask_op   = dltq_pkg::MASK_CLR_RD;
          ctl_o.idx_op    = dltq_pkg::IDX_INC;
        end
      end

      // Compact the tail down by the shift distance
      S_MOVE: begin
        if (stat_i.at_end) begin
          ctl_o.cnt_op = dltq_pkg::CNT_SUB_SHIFT;
          if (stat_i.cmd == dltq_pkg::CMD_DEL) begin
            ctl_o.mask_op     = dltq_pkg::MASK_CLR_ID;
            ctl_o.emit        = 1'b1;
            ctl_o.emit_status = dltq_pkg::ST_DONE;
            ctl_o.emit_id     = dltq_pkg::EID_CMD;
            ctl_o.emit_last   = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          ctl_o.wr_en   = 1'b1;
          ctl_o.wr_src  = dltq_pkg::WR_MOVED;
          ctl_o.wr_back = 1'b1;
          ctl_o.rem_op  = dltq_pkg::REM_CLR;
          ctl_o.idx_op  = dltq_pkg::IDX_INC;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  // An expired report that is not the last is followed at once by another
  a_expired_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.emit && !ctl_o.emit_last |=> ctl_o.emit)
    else $error("result run ended without a last result");

  // Nothing is written or reported while waiting for a command
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !ctl_o.emit && !ctl_o.wr_en)
    else $error("activity while idle");

  // Without start the controller stays idle
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE && !start_i |=> state_q == S_IDLE)
    else $error("left idle without start");
`endif

endmodule

`default_nettype wire

### rtl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: controller plus datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_dp.
`timescale 1ns / 1ps
`default_nettype none

// Timer queue kept as a sorted delta list in a single-port-read memory. A
// command (add, delete, tick) is taken when start_i is high and busy_o low.
// A command that walks the list moves one memory slot per cycle through one
// read and one write port while busy_o stays high, and the next command can
// be taken as soon as busy_o falls; rejected adds, deletes of absent timers
// and ticks that expire nothing at the head end in the dispatch step without
// walking the list. Results come out on result_valid_o, one per cycle, for
// one cycle each, and cannot be held off: a tick that expires several timers
// reports them in list order on consecutive cycles, last_o marking the final
// one. No clearing pass is needed after reset.
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [dltq_pkg::CMD_W-1:0]    cmd_i,
  input  logic [dltq_pkg::ID_W-1:0]     timer_id_i,
  input  logic [dltq_pkg::DELTA_W-1:0]  delay_ticks_i,
  output logic                          result_valid_o,
  output logic [dltq_pkg::STATUS_W-1:0] status_o,
  output logic [dltq_pkg::ID_W-1:0]     fired_id_o,
  output logic                          last_o
);

  dltq_pkg::dp_ctl_t  ctl;
  dltq_pkg::dp_stat_t stat;

  dltq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  dltq_dp #(
    .NUM_TIMERS(NUM_TIMERS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .timer_id_i    (timer_id_i),
    .delay_ticks_i (delay_ticks_i),
    .result_valid_o(result_valid_o),
    .status_o      (status_o),
    .fired_id_o    (fired_id_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
